// ----- src/cbd_pkg.sv -----
package cbd_pkg;

    // Field widths of the channels
    localparam int CMD_W      = 2;
    localparam int DATA_W     = 8;
    localparam int RESULT_W   = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    // Register widths and reset values
    localparam int BC_W     = 5;
    localparam int DU_W     = 6;
    localparam int BC_RESET = 16;
    localparam int DU_RESET = 1;

    // Result queue depth; also bounds the number of items in flight
    localparam int OUT_QDEPTH = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_BIT   = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BRANCH_COUNT = 1'b0,
        REG_DELAY_UNIT   = 1'b1
    } reg_idx_t;

    // One bit moved through a branch, as seen by the output stage
    typedef struct packed {
        logic vld;   // a bit went through a branch this cycle
        logic last;  // last bit of its item
        logic wide;  // item is a byte command
        logic pass;  // branch has zero length: bit passes straight through
        logic hit;   // branch delay line has wrapped, memory data is live
        logic din;   // bit pushed into the branch
    } step_t;

endpackage

// ----- src/cbd_if.sv -----
// Command item channel
interface cbd_req_if import cbd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] data;

    modport source (output valid, output cmd, output data, input ready);
    modport sink   (input valid, input cmd, input data, output ready);
endinterface

// Result item channel
interface cbd_rsp_if import cbd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [RESULT_W-1:0] result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

// Register write channel
interface cbd_cfg_if import cbd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/cbd_store.sv -----
module cbd_store import cbd_pkg::*; #(
    parameter int DEPTH  = 3840,
    parameter int ADDR_W = 12
) (
    input  logic              clk,
    input  logic              en,
    input  logic [ADDR_W-1:0] addr,
    input  logic              wdata,
    output logic              rdata
);

    logic mem [DEPTH];
    logic rdata_reg;

    // Single port, read returns the old bit while the new one is written
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg  <= mem[addr];
            mem[addr]  <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/cbd_sched.sv -----
module cbd_sched import cbd_pkg::*; #(
    parameter int MAX_BRANCHES   = 16,
    parameter int MAX_DELAY_UNIT = 32,
    parameter int ADDR_W         = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  logic [CMD_W-1:0]      cmd,
    input  logic [DATA_W-1:0]     data,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  pop,
    output logic                  mem_en,
    output logic [ADDR_W-1:0]     mem_addr,
    output logic                  mem_wdata,
    output step_t                 step
);

    localparam int MAX_LEN = (MAX_BRANCHES - 1) * MAX_DELAY_UNIT;
    localparam int LEN_W   = (MAX_LEN > 0) ? $clog2(MAX_LEN + 1) : 1;
    localparam int IDX_W   = (MAX_BRANCHES > 1) ? $clog2(MAX_BRANCHES) : 1;
    localparam int BCNT_W  = $clog2(MAX_BRANCHES + 1);
    localparam int M_W     = $clog2(MAX_DELAY_UNIT + 1);
    localparam int PEND_W  = $clog2(OUT_QDEPTH + 1);

    logic [BC_W-1:0]   bc_reg, bc_next;
    logic [DU_W-1:0]   du_reg, du_next;
    logic [IDX_W-1:0]  comm_reg, comm_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  ptr_reg [MAX_BRANCHES];
    logic [LEN_W-1:0]  ptr_next [MAX_BRANCHES];
    logic [MAX_BRANCHES-1:0] hit_reg, hit_next;
    logic [2:0]        rem_reg, rem_next;
    logic [6:0]        sh_reg, sh_next;
    logic [PEND_W-1:0] pend_reg, pend_next;
    step_t             step_reg, step_next;

    logic [BCNT_W-1:0] b_eff;
    logic [M_W-1:0]    m_eff;
    logic [LEN_W-1:0]  bm1_ext, m_ext, full_len;
    logic [LEN_W-1:0]  len_cur, p, p_inc;
    logic [ADDR_W-1:0] base_cur;
    logic              acc, take_bit, take_byte, take_clear;
    logic              do_step, pass, wrap, push_bit, last_bit, comm_wrap;

    // Saturate the configured geometry
    always_comb
    begin
        if (bc_reg == '0)
            b_eff = BCNT_W'(1);
        else if (32'(bc_reg) > MAX_BRANCHES)
            b_eff = BCNT_W'(MAX_BRANCHES);
        else
            b_eff = BCNT_W'(bc_reg);

        if (32'(du_reg) > MAX_DELAY_UNIT)
            m_eff = M_W'(MAX_DELAY_UNIT);
        else
            m_eff = M_W'(du_reg);
    end

    // Length of branch 0; later branches are stepped down by M
    assign bm1_ext  = LEN_W'(b_eff - BCNT_W'(1));
    assign m_ext    = LEN_W'(m_eff);
    assign full_len = bm1_ext * m_ext;

    // Command decode
    assign acc = req_valid && req_ready;
    always_comb
    begin
        take_bit   = 1'b0;
        take_byte  = 1'b0;
        take_clear = 1'b0;
        unique case (cmd_t'(cmd))
            CMD_BIT:   take_bit   = acc;
            CMD_BYTE:  take_byte  = acc;
            CMD_CLEAR: take_clear = acc;
            default:   ;
        endcase
    end

    assign req_ready = (rem_reg == '0) && (pend_reg < PEND_W'(OUT_QDEPTH));
    assign do_step   = take_bit || take_byte || (rem_reg != '0);
    assign last_bit  = take_bit || (rem_reg == 3'd1);

    // Bit for this step: first bit straight from the item, the rest from the shifter
    always_comb
    begin
        priority if (take_bit)
            push_bit = data[0];
        else if (take_byte)
            push_bit = data[7];
        else
            push_bit = sh_reg[6];
    end

    // Current branch geometry
    assign len_cur   = (comm_reg == '0) ? full_len : len_reg;
    assign base_cur  = (comm_reg == '0) ? '0 : base_reg;
    assign p         = ptr_reg[comm_reg];
    assign p_inc     = p + LEN_W'(1);
    assign wrap      = (p_inc == len_cur);
    assign pass      = (len_cur == '0);
    assign comm_wrap = (BCNT_W'(comm_reg) + BCNT_W'(1) == b_eff);

    assign mem_en    = do_step && !pass;
    assign mem_addr  = base_cur + ADDR_W'(p);
    assign mem_wdata = push_bit;

    // Next state
    always_comb
    begin
        bc_next   = bc_reg;
        du_next   = du_reg;
        comm_next = comm_reg;
        base_next = base_reg;
        len_next  = len_reg;
        ptr_next  = ptr_reg;
        hit_next  = hit_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;

        if (do_step)
        begin
            comm_next = comm_wrap ? '0 : comm_reg + IDX_W'(1);
            base_next = base_cur + ADDR_W'(len_cur);
            len_next  = len_cur - LEN_W'(m_eff);
            if (!pass)
            begin
                ptr_next[comm_reg] = wrap ? '0 : p_inc;
                if (wrap)
                    hit_next[comm_reg] = 1'b1;
            end
        end

        // Byte sequencing
        if (take_byte)
        begin
            rem_next = 3'd7;
            sh_next  = data[6:0];
        end
        else if (rem_reg != '0)
        begin
            rem_next = rem_reg - 3'd1;
            sh_next  = {sh_reg[5:0], 1'b0};
        end

        // Register writes store and then clear like the clear command
        if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_BRANCH_COUNT: bc_next = cfg_data[BC_W-1:0];
                REG_DELAY_UNIT:   du_next = cfg_data[DU_W-1:0];
            endcase
        end

        if (take_clear || cfg_valid)
        begin
            comm_next = '0;
            for (int k = 0; k < MAX_BRANCHES; k++)
                ptr_next[k] = '0;
            hit_next  = '0;
        end
    end

    // Outstanding results, bounded by the result queue
    always_comb
    begin
        pend_next = pend_reg;
        if ((take_bit || take_byte) && !pop)
            pend_next = pend_reg + PEND_W'(1);
        else if (!(take_bit || take_byte) && pop)
            pend_next = pend_reg - PEND_W'(1);
    end

    // Step record for the output stage, aligned with memory read data
    always_comb
    begin
        step_next.vld  = do_step;
        step_next.last = last_bit;
        step_next.wide = take_byte || (rem_reg != '0);
        step_next.pass = pass;
        step_next.hit  = hit_reg[comm_reg];
        step_next.din  = push_bit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bc_reg   <= BC_W'(BC_RESET);
            du_reg   <= DU_W'(DU_RESET);
            comm_reg <= '0;
            base_reg <= '0;
            len_reg  <= '0;
            for (int k = 0; k < MAX_BRANCHES; k++)
                ptr_reg[k] <= '0;
            hit_reg  <= '0;
            rem_reg  <= '0;
            pend_reg <= '0;
            step_reg <= '0;
        end
        else
        begin
            bc_reg   <= bc_next;
            du_reg   <= du_next;
            comm_reg <= comm_next;
            base_reg <= base_next;
            len_reg  <= len_next;
            ptr_reg  <= ptr_next;
            hit_reg  <= hit_next;
            rem_reg  <= rem_next;
            pend_reg <= pend_next;
            step_reg <= step_next;
        end
    end

    // Shifter holds payload only
    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
    end

    assign step = step_reg;

endmodule

// ----- src/cbd_pack.sv -----
module cbd_pack import cbd_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  step_t               step,
    input  logic                rdata,
    input  logic                pop,
    output logic                valid,
    output logic [RESULT_W-1:0] result
);

    localparam int QA_W = (OUT_QDEPTH > 1) ? $clog2(OUT_QDEPTH) : 1;
    localparam int QC_W = $clog2(OUT_QDEPTH + 1);

    logic [RESULT_W-1:0] q_reg [OUT_QDEPTH];
    logic [QA_W-1:0]     wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [QC_W-1:0]     cnt_reg, cnt_next;
    logic [6:0]          acc_reg;
    logic                out_bit, push;
    logic [RESULT_W-1:0] push_val;

    // Bit out of the branch: live memory data only once the line has wrapped
    assign out_bit  = step.pass ? step.din : (step.hit & rdata);
    assign push     = step.vld && step.last;
    assign push_val = step.wide ? {acc_reg, out_bit} : {7'b0, out_bit};

    // Queue pointers
    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
            wptr_next = (32'(wptr_reg) == OUT_QDEPTH - 1) ? '0 : wptr_reg + QA_W'(1);
        if (pop)
            rptr_next = (32'(rptr_reg) == OUT_QDEPTH - 1) ? '0 : rptr_reg + QA_W'(1);
        if (push && !pop)
            cnt_next = cnt_reg + QC_W'(1);
        else if (!push && pop)
            cnt_next = cnt_reg - QC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Byte assembly and queue storage
    always_ff @(posedge clk)
    begin
        if (step.vld)
            acc_reg <= {acc_reg[5:0], out_bit};
        if (push)
            q_reg[wptr_reg] <= push_val;
    end

    assign valid  = (cnt_reg != '0);
    assign result = q_reg[rptr_reg];

endmodule

// ----- src/convolutional_bit_deinterleaver.sv -----
// Convolutional (Forney) bit deinterleaver. A bit command moves one bit and a byte command
// eight, one bit per cycle, since every bit is one read-modify-write of the single-port delay
// memory; a new command can be taken at the earliest in the cycle after the last bit of the
// previous one. The result of an item is registered in the step record at the clock edge that
// moves its last bit and then written into the result queue, which offers it. Results wait in a
// four-entry queue, so the block keeps accepting commands while the sink stalls until four
// results are outstanding. All delay lines share one bit memory of
// MAX_BRANCHES*(MAX_BRANCHES-1)/2*MAX_DELAY_UNIT entries; each branch has a fill flag, so a
// clear command or a register write takes effect with no clearing pass, and a branch reads
// as zero until its line has wrapped. Register writes restart the commutator and empty every
// delay line.
module convolutional_bit_deinterleaver import cbd_pkg::*; #(
    parameter int MAX_BRANCHES   = 16,
    parameter int MAX_DELAY_UNIT = 32
) (
    input  logic    clk,
    input  logic    rst_n,
    cbd_req_if.sink   req,
    cbd_rsp_if.source rsp,
    cbd_cfg_if.sink   cfg
);

    localparam int RAW_DEPTH = MAX_BRANCHES * (MAX_BRANCHES - 1) / 2 * MAX_DELAY_UNIT;
    localparam int DEPTH     = (RAW_DEPTH > 0) ? RAW_DEPTH : 1;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic              mem_en, mem_wdata, mem_rdata, pop;
    logic [ADDR_W-1:0] mem_addr;
    step_t             step;

    assign cfg.ready = 1'b1;
    assign pop       = rsp.valid && rsp.ready;

    cbd_sched #(
        .MAX_BRANCHES   (MAX_BRANCHES),
        .MAX_DELAY_UNIT (MAX_DELAY_UNIT),
        .ADDR_W         (ADDR_W)
    ) u_sched (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .cmd       (req.cmd),
        .data      (req.data),
        .cfg_valid (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .pop       (pop),
        .mem_en    (mem_en),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .step      (step)
    );

    cbd_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .en    (mem_en),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    cbd_pack u_pack (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .rdata  (mem_rdata),
        .pop    (pop),
        .valid  (rsp.valid),
        .result (rsp.result)
    );

    // Checks
    logic acc_bit, acc_byte;
    assign acc_bit  = req.valid && req.ready && (req.cmd == CMD_BIT);
    assign acc_byte = req.valid && req.ready && (req.cmd == CMD_BYTE);

    // a bit command is one single-bit step
    a_bit_step: assert property (@(posedge clk) disable iff (!rst_n)
        acc_bit |=> (step.vld && step.last && !step.wide))
        else $error("bit command did not issue a single last step");

    // a byte command ends with its eighth step
    a_byte_steps: assert property (@(posedge clk) disable iff (!rst_n)
        acc_byte |-> ##8 (step.vld && step.last && step.wide))
        else $error("byte command did not finish after eight steps");

    // the last step of an item always lands in the result queue
    a_result_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (step.vld && step.last) |=> rsp.valid)
        else $error("finished item missing from result queue");

endmodule

// ----- tb/convolutional_bit_deinterleaver_tb.sv -----
module convolutional_bit_deinterleaver_tb import cbd_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // Geometry limits of the default build
    localparam int MAX_BR     = 16;
    localparam int MAX_DU     = 32;
    localparam int LINE_BITS  = MAX_BR * (MAX_BR - 1) / 2 * MAX_DU + 1;
    localparam int SETTLE     = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam int MAX_WAIT   = 17;

    // Command code that the block must ignore
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic clk;
    logic rst_n;

    cbd_req_if req_ch ();
    cbd_rsp_if rsp_ch ();
    cbd_cfg_if cfg_ch ();

    convolutional_bit_deinterleaver dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Deinterleaver state as predicted
    bit                line_bits [LINE_BITS];
    int unsigned       line_pos [MAX_BR];
    int unsigned       branch_sel;
    logic [BC_W-1:0]   model_branches;
    logic [DU_W-1:0]   model_delay;

    logic [RESULT_W-1:0] pending_results [$];

    // Run bookkeeping
    int unsigned cycle_count;
    int unsigned error_count;
    int unsigned items_sent;
    int unsigned items_ignored;
    int unsigned results_seen;
    int unsigned reg_writes;
    int unsigned input_stalls;

    // Idling control shared with the result side
    bit          tx_idle;
    bit          rx_idle;
    int unsigned stall_left;
    int unsigned hold_req;
    int unsigned hold_left;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("convolutional_bit_deinterleaver test failed");
        $finish;
    end

    function automatic int unsigned draw_wait(bit idle_on);
        return idle_on ? $urandom_range(0, MAX_WAIT) : 0;
    endfunction

    function automatic void clear_lines();
        foreach (line_bits[a])
            line_bits[a] = 1'b0;
        foreach (line_pos[b])
            line_pos[b] = 0;
        branch_sel = 0;
    endfunction

    // Expected result goes to the tail of the queue
    function automatic void queue_result(logic [RESULT_W-1:0] res);
        pending_results = {pending_results, res};
    endfunction

    // One bit through the branch under the commutator, then step the commutator
    function automatic bit shift_branch_bit(bit din);
        int unsigned nb;
        int unsigned step;
        int unsigned br;
        int unsigned len;
        int unsigned base;
        int unsigned p;
        int unsigned addr;
        bit          dout;
        nb = (model_branches == 0) ? 1 :
             ((model_branches > MAX_BR) ? MAX_BR : model_branches);
        step = (model_delay > MAX_DU) ? MAX_DU : model_delay;
        br = branch_sel % nb;
        len = (nb - 1 - br) * step;
        // lines are packed longest first
        base = step * (br * (nb - 1) - (br * (br - ((br > 0) ? 1 : 0))) / 2);
        dout = din;
        if (len > 0)
        begin
            p = line_pos[br] % len;
            addr = base + p;
            if (addr < LINE_BITS)
            begin
                dout = line_bits[addr];
                line_bits[addr] = din;
            end
            p++;
            if (p >= len)
                p = 0;
            line_pos[br] = p;
        end
        branch_sel = (br + 1) % nb;
        return dout;
    endfunction

    function automatic void deinterleave_item(logic [CMD_W-1:0] op, logic [DATA_W-1:0] din);
        logic [RESULT_W-1:0] res;
        res = '0;
        case (op)
            CMD_BIT:
            begin
                res[0] = shift_branch_bit(din[0]);
                queue_result(res);
            end
            CMD_BYTE:
            begin
                // MSB goes in first
                for (int k = 7; k >= 0; k--)
                    res[k] = shift_branch_bit(din[k]);
                queue_result(res);
            end
            CMD_CLEAR:
                clear_lines();
            default:
                ;
        endcase
    endfunction

    // Send one command item; valid stays up until the next call or a stop
    task automatic send_item(logic [CMD_W-1:0] op, logic [DATA_W-1:0] din);
        int unsigned gap;
        gap = draw_wait(tx_idle);
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd   <= op;
        req_ch.data  <= din;
        do
            @(posedge clk);
        while (!req_ch.ready);
        deinterleave_item(op, din);
        if (op == CMD_UNUSED)
            items_ignored++;
        else
            items_sent++;
    endtask

    task automatic sender_stop();
        @(negedge clk);
        req_ch.valid <= 1'b0;
    endtask

    // Let every expected result arrive, then let cleared commands settle
    task automatic go_idle();
        sender_stop();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (idx == REG_BRANCH_COUNT)
            model_branches = val[BC_W-1:0];
        else
            model_delay = val[DU_W-1:0];
        clear_lines();
        reg_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Result side: ready pattern driven at the falling edge
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Result check at the rising edge
    initial
    begin
        logic [RESULT_W-1:0] want;
        forever
        begin
            @(posedge clk);
            if (rst_n && req_ch.valid && !req_ch.ready)
                input_stalls++;
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                results_seen++;
                stall_left = draw_wait(rx_idle);
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result item: result %h", rsp_ch.result);
                    error_count++;
                end
                else
                begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    if (rsp_ch.result !== want)
                    begin
                        $error("result: expected %h, actual %h", want, rsp_ch.result);
                        error_count++;
                    end
                end
            end
        end
    end

    // Reset geometry (16 branches, unit 1): data extremes, all commands
    task automatic test_reset_defaults();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_item(CMD_BIT, 8'hFF);
        send_item(CMD_BIT, 8'hFE);   // upper bits ignored in bit mode
        send_item(CMD_BIT, 8'h01);
        send_item(CMD_BYTE, 8'h00);
        send_item(CMD_BYTE, 8'hFF);
        send_item(CMD_BYTE, 8'hA5);
        send_item(CMD_UNUSED, 8'hFF);
        send_item(CMD_BYTE, 8'h5A);
        send_item(CMD_CLEAR, 8'hFF);
        send_item(CMD_BYTE, 8'hFF);
        send_item(CMD_BYTE, 8'h80);
        send_item(CMD_BIT, 8'h00);
        send_item(CMD_BYTE, 8'h01);
    endtask

    task automatic run_settings(logic [CFG_DATA_W-1:0] bc, logic [CFG_DATA_W-1:0] du,
                                int unsigned n_bytes);
        go_idle();
        write_reg(REG_BRANCH_COUNT, bc);
        write_reg(REG_DELAY_UNIT, du);
        repeat (n_bytes) send_item(CMD_BYTE, 8'($urandom_range(0, 255)));
        send_item(CMD_BIT, 8'($urandom_range(0, 255)));
    endtask

    // Zero and saturated register values
    task automatic test_register_extremes();
        run_settings(6'd0, 6'd0, 2);     // one branch, no delay
        run_settings(6'd63, 6'd63, 2);   // both saturate
        run_settings(6'd1, 6'd33, 2);    // one branch, unit saturates
        run_settings(6'd16, 6'd0, 2);    // zero unit: all pass
    endtask

    task automatic run_phase(logic [CFG_DATA_W-1:0] bc, logic [CFG_DATA_W-1:0] du,
                             int unsigned n_items);
        int unsigned roll;
        int unsigned done;
        logic [CMD_W-1:0] op;
        go_idle();
        write_reg(REG_BRANCH_COUNT, bc);
        write_reg(REG_DELAY_UNIT, du);
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
        done = 0;
        while (done < n_items)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 58)
                op = CMD_BYTE;
            else if (roll < 94)
                op = CMD_BIT;
            else if (roll < 97)
                op = CMD_CLEAR;
            else
                op = CMD_UNUSED;
            send_item(op, 8'($urandom_range(0, 255)));
            if (op != CMD_UNUSED)
                done++;
        end
    endtask

    // Random traffic over a spread of geometries, most small enough for the lines to wrap
    task automatic test_random_geometries();
        logic [CFG_DATA_W-1:0] geo_b [10] = '{6'd4, 6'd16, 6'd1, 6'd2, 6'd8,
                                              6'd31, 6'd7, 6'd16, 6'd3, 6'd5};
        logic [CFG_DATA_W-1:0] geo_m [10] = '{6'd3, 6'd1, 6'd5, 6'd32, 6'd2,
                                              6'd4, 6'd63, 6'd32, 6'd33, 6'd1};
        int unsigned counts [10] = '{130, 170, 50, 100, 130, 130, 170, 80, 80, 90};
        foreach (counts[g])
            run_phase(geo_b[g], geo_m[g], counts[g]);
    endtask

    // Long result stall while items keep coming: the block must stop taking input
    task automatic test_output_backpressure();
        go_idle();
        write_reg(REG_BRANCH_COUNT, 6'd4);
        write_reg(REG_DELAY_UNIT, 6'd2);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        hold_req = 300;
        repeat (40) send_item(CMD_BYTE, 8'($urandom_range(0, 255)));
    endtask

    // Sender pauses until all results are back, state carries over
    task automatic test_sender_pause();
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        repeat (30) send_item(CMD_BYTE, 8'($urandom_range(0, 255)));
        sender_stop();
        while (pending_results.size() != 0)
            @(posedge clk);
        tx_idle = 1'b1;
        repeat (30) send_item(CMD_BIT, 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.cmd = CMD_BIT;
        req_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_BRANCH_COUNT;
        cfg_ch.data = '0;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        stall_left = 0;
        hold_req = 0;
        hold_left = 0;
        model_branches = BC_W'(BC_RESET);
        model_delay = DU_W'(DU_RESET);
        clear_lines();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_output_backpressure();
        test_sender_pause();
        test_random_geometries();

        go_idle();
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            error_count++;
        end
        $display("Sent %0d command items plus %0d unused codes, checked %0d results.",
                 items_sent, items_ignored, results_seen);
        $display("Applied %0d register writes; input was held off for %0d cycles.",
                 reg_writes, input_stalls);
        if (error_count == 0)
            $display("convolutional_bit_deinterleaver test passed");
        else
            $display("convolutional_bit_deinterleaver test failed");
        $finish;
    end

endmodule

// ----- convolutional_bit_deinterleaver.f -----
src/cbd_pkg.sv
src/cbd_if.sv
src/cbd_store.sv
src/cbd_sched.sv
src/cbd_pack.sv
src/convolutional_bit_deinterleaver.sv
tb/convolutional_bit_deinterleaver_tb.sv
